// ===== src/refraction_fresnel_unit_assert.svh =====
// Assertion macros for the refraction and Fresnel unit.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef REFRACTION_FRESNEL_UNIT_ASSERT_SVH
`define REFRACTION_FRESNEL_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define RFU_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define RFU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

// A condition that implies another in the same cycle.
`define RFU_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== src/rfu_pkg.sv =====
// Constants and the pipeline payload type of the refraction and Fresnel unit.
// Depends on nothing; used by refraction_fresnel_unit.
package rfu_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IDX_FRAC  = 13;
	localparam logic [14:0] ONE = 15'(1 << FRAC_BITS);

	// Pipeline layout.
	localparam int NUM_STAGES = 16;
	localparam int SQ_FIRST   = 3;
	localparam int SQ_LAST    = 6;
	localparam int SQ_PER_STG = 4;
	localparam int SQ_STEPS   = 15;
	localparam int DIV_FIRST  = 9;
	localparam int DIV_LAST   = 13;
	localparam int DIV_PER_STG = 3;
	localparam int DIV_TOP    = FRAC_BITS;

	typedef struct packed {
		logic [2:0][15:0] n;
		logic [14:0]      c;
		logic [15:0]      ei;
		logic [15:0]      et;
		logic [31:0]      eta2;
		logic [28:0]      c2;
		logic [30:0]      etac;
		logic [2:0][32:0] etad;
		logic [30:0]      etc_p;
		logic [30:0]      eic_p;
		logic [46:0]      prod;
		logic             tir;
		logic [29:0]      sq_v;
		logic [29:0]      sq_res;
		logic [18:0]      m;
		logic [2:0][20:0] a;
		logic [30:0]      fb1;
		logic [30:0]      fb2;
		logic [2:0][34:0] bn;
		logic [2:0][15:0] comp;
		logic [31:0]      den1;
		logic [31:0]      den2;
		logic [46:0]      rem1;
		logic [46:0]      rem2;
		logic [14:0]      q1;
		logic [14:0]      q2;
		logic             z1;
		logic             z2;
		logic [15:0]      t1;
		logic [15:0]      t2;
		logic [14:0]      refl;
	} pipe_t;

endpackage

// ===== src/refraction_fresnel_unit.sv =====
// Top level of the refraction and Fresnel unit: a sixteen-stage pipeline.
// Depends on rfu_pkg and on refraction_fresnel_unit_assert.svh.
//
// This block takes one request per cycle while the result side is ready and
// returns one result per request, in order; a result is valid on the outputs
// once its request reaches the last pipeline stage. Each request
// carries an incident direction and a surface normal in
// signed Q1.14, the incident cosine in Q1.14, and three indices in Q3.13. The
// block forms k = 1 - eta^2 (1 - cos^2); when k is negative the ray is totally
// reflected, the direction comes out as zero and the reflectance as one.
// Otherwise the refracted direction eta*d + n*(eta*cos - sqrt(k)) is returned,
// each component saturated to 16 bits, with the dielectric Fresnel
// reflectance, the mean of the squared s and p terms. The latency is set by
// the square root (fifteen digit steps spread over four stages) and by the two
// Fresnel quotients that follow it (fifteen restoring steps over five stages).
// Every stage holds a valid bit and stalls only while the stage after it is
// full and stalled, so with result_ready high a full pipeline keeps one
// request per cycle flowing, and a stall on the result side loses nothing.
// There is no configuration and no state carries from one request to the next.
module refraction_fresnel_unit
	import rfu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic signed [15:0] incident_x,
	input  logic signed [15:0] incident_y,
	input  logic signed [15:0] incident_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic        [14:0] cos_incident,
	input  logic        [15:0] eta_ratio,
	input  logic        [15:0] eta_ray,
	input  logic        [15:0] eta_surface,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [15:0] refracted_x,
	output logic signed [15:0] refracted_y,
	output logic signed [15:0] refracted_z,
	output logic               total_reflection,
	output logic        [14:0] reflectance
);

`include "refraction_fresnel_unit_assert.svh"

	localparam logic [46:0] LIM = 47'(1) << (FRAC_BITS + 2 * IDX_FRAC);

	pipe_t                  pipe_s [NUM_STAGES];
	pipe_t                  nx     [NUM_STAGES];
	logic [NUM_STAGES-1:0]  vld_s;
	logic [NUM_STAGES:0]    adv;

	function automatic logic [15:0] sat16(input logic signed [22:0] v);
		if (v > 23'sd32767) begin
			return 16'h7fff;
		end else if (v < -23'sd32768) begin
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	// A stage loads when it is empty or when the stage after it loads.
	always_comb begin
		adv[NUM_STAGES] = result_ready;
		for (int g = NUM_STAGES - 1; g >= 0; g--) begin
			adv[g] = !vld_s[g] || adv[g+1];
		end
	end

	assign item_ready = adv[0];

	// Work done in front of each pipeline register.
	always_comb begin
		pipe_t               p;
		logic [14:0]         cc;
		logic [14:0]         s;
		logic [14:0]         k;
		logic [29:0]         bitv;
		logic [46:0]         sub;
		logic [17:0]         rc;
		logic [33:0]         ra;
		logic [35:0]         rb;
		logic [29:0]         qq;
		logic [16:0]         tsum;
		logic [15:0]         avg;
		logic signed [15:0]  dv [3];
		logic [30:0]         nm1;
		logic [30:0]         nm2;
		int                  t;
		int                  j;

		dv[0] = incident_x;
		dv[1] = incident_y;
		dv[2] = incident_z;
		cc = (cos_incident > ONE) ? ONE : cos_incident;
		for (int g = 0; g < NUM_STAGES; g++) begin
			if (g == 0) begin
				p = '0;
				p.n[0]  = normal_x;
				p.n[1]  = normal_y;
				p.n[2]  = normal_z;
				p.c     = cc;
				p.ei    = eta_ray;
				p.et    = eta_surface;
				p.eta2  = eta_ratio * eta_ratio;
				p.c2    = 29'(cc * cc);
				p.etac  = 31'(eta_ratio * cc);
				for (int i = 0; i < 3; i++) begin
					p.etad[i] = 33'($signed({1'b0, eta_ratio}) * dv[i]);
				end
				p.etc_p = 31'(eta_surface * cc);
				p.eic_p = 31'(eta_ray * cc);
			end else begin
				p = pipe_s[g-1];
			end

			if (g == 1) begin
				s = 15'(((29'(1) << (2 * FRAC_BITS)) - p.c2) >> FRAC_BITS);
				p.prod = 47'(p.eta2 * s);
			end else if (g == 2) begin
				p.tir = p.prod > LIM;
				k = p.tir ? 15'd0 : 15'((LIM - p.prod) >> (2 * IDX_FRAC));
				p.sq_v = {1'b0, k, 14'd0};
				p.sq_res = '0;
			end else if (g >= SQ_FIRST && g <= SQ_LAST) begin
				// Digit-by-digit square root, two radicand bits per step.
				for (int u = 0; u < SQ_PER_STG; u++) begin
					t = SQ_PER_STG * (g - SQ_FIRST) + u;
					if (t < SQ_STEPS) begin
						bitv = 30'(1) << (2 * (SQ_STEPS - 1) - 2 * t);
						if (p.sq_v >= p.sq_res + bitv) begin
							p.sq_v = p.sq_v - (p.sq_res + bitv);
							p.sq_res = (p.sq_res >> 1) + bitv;
						end else begin
							p.sq_res = p.sq_res >> 1;
						end
					end
				end
			end else if (g == 7) begin
				rc = 18'(({1'b0, p.etac} + 32'd4096) >> IDX_FRAC);
				p.m = $signed({1'b0, rc}) - $signed({4'd0, p.sq_res[14:0]});
				for (int i = 0; i < 3; i++) begin
					ra = $signed({p.etad[i][32], p.etad[i]}) + 34'sd4096;
					p.a[i] = ra[33:13];
				end
				p.fb1 = 31'(p.ei * p.sq_res[14:0]);
				p.fb2 = 31'(p.et * p.sq_res[14:0]);
			end else if (g == 8) begin
				for (int i = 0; i < 3; i++) begin
					p.bn[i] = 35'($signed(p.n[i]) * $signed(p.m));
				end
				nm1 = (p.etc_p > p.fb1) ? p.etc_p - p.fb1 : p.fb1 - p.etc_p;
				nm2 = (p.eic_p > p.fb2) ? p.eic_p - p.fb2 : p.fb2 - p.eic_p;
				p.den1 = {1'b0, p.etc_p} + {1'b0, p.fb1};
				p.den2 = {1'b0, p.eic_p} + {1'b0, p.fb2};
				p.z1 = p.den1 == '0;
				p.z2 = p.den2 == '0;
				p.rem1 = {2'b0, nm1, 14'd0} + 47'(p.den1 >> 1);
				p.rem2 = {2'b0, nm2, 14'd0} + 47'(p.den2 >> 1);
				p.q1 = '0;
				p.q2 = '0;
			end

			if (g == DIV_FIRST) begin
				for (int i = 0; i < 3; i++) begin
					rb = $signed({p.bn[i][34], p.bn[i]}) + 36'sd8192;
					p.comp[i] = sat16($signed({{2{p.a[i][20]}}, p.a[i]})
						+ $signed({rb[35], rb[35:14]}));
				end
			end

			if (g >= DIV_FIRST && g <= DIV_LAST) begin
				// Restoring division, one quotient bit per step.
				for (int u = 0; u < DIV_PER_STG; u++) begin
					j = DIV_TOP - DIV_PER_STG * (g - DIV_FIRST) - u;
					sub = 47'(p.den1) << j;
					if (p.rem1 >= sub) begin
						p.rem1 = p.rem1 - sub;
						p.q1[j] = 1'b1;
					end
					sub = 47'(p.den2) << j;
					if (p.rem2 >= sub) begin
						p.rem2 = p.rem2 - sub;
						p.q2[j] = 1'b1;
					end
				end
			end else if (g == 14) begin
				qq = p.q1 * p.q1;
				p.t1 = p.z1 ? 16'(ONE) : 16'((31'(qq) + 31'd8192) >> FRAC_BITS);
				qq = p.q2 * p.q2;
				p.t2 = p.z2 ? 16'(ONE) : 16'((31'(qq) + 31'd8192) >> FRAC_BITS);
			end else if (g == 15) begin
				tsum = 17'(p.t1) + 17'(p.t2) + 17'd1;
				avg = tsum[16:1];
				if (p.tir) begin
					p.refl = ONE;
					p.comp = '0;
				end else begin
					p.refl = (avg > 16'h7fff) ? 15'h7fff : avg[14:0];
				end
			end

			nx[g] = p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= item_valid;
			end
			for (int g = 1; g < NUM_STAGES; g++) begin
				if (adv[g]) begin
					vld_s[g] <= vld_s[g-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NUM_STAGES; g++) begin
			if (adv[g]) begin
				pipe_s[g] <= nx[g];
			end
		end
	end

	assign result_valid     = vld_s[NUM_STAGES-1];
	assign refracted_x      = pipe_s[NUM_STAGES-1].comp[0];
	assign refracted_y      = pipe_s[NUM_STAGES-1].comp[1];
	assign refracted_z      = pipe_s[NUM_STAGES-1].comp[2];
	assign total_reflection = pipe_s[NUM_STAGES-1].tir;
	assign reflectance      = pipe_s[NUM_STAGES-1].refl;

	// A totally reflected ray leaves no direction and full reflectance.
	`RFU_ASSERT_IMPL(a_tir_out, result_valid && total_reflection, refracted_x == 16'sd0 && refracted_y == 16'sd0 && refracted_z == 16'sd0 && reflectance == ONE, "total reflection result is not clean")
	// The reflectance never exceeds one.
	`RFU_ASSERT_IMPL(a_refl_range, result_valid, reflectance <= ONE, "reflectance above one")
	// An accepted request always lands in the first stage.
	`RFU_ASSERT_NEXT(a_accept_lands, item_valid && item_ready, vld_s[0], "accepted request was lost")
	// A full pipeline with a stalled output takes no new request.
	`RFU_ASSERT_ALWAYS(a_full_stall, !((&vld_s) && !result_ready && item_ready), "request taken while full and stalled")

endmodule
